// ===== src/oversampled_gcr_telemetry_decoder_core_assert.svh =====
`ifndef OVERSAMPLED_GCR_TELEMETRY_DECODER_CORE_ASSERT_SVH
`define OVERSAMPLED_GCR_TELEMETRY_DECODER_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define OGTD_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ogtd assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define OGTD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ogtd assertion failed");

`endif

// ===== src/ogtd_pkg.sv =====
package ogtd_pkg;

    // payload of one input transaction
    typedef struct packed {
        logic [15:0] port_sample;
        logic        last_sample;
    } sample_t;

    // payload of one result transaction
    typedef struct packed {
        logic [1:0]  status;
        logic [11:0] telemetry;
    } result_t;

    // what the tracker hands to the frame decoder
    typedef struct packed {
        logic        window_ok;
        logic [6:0]  bit_total;
        logic [20:0] run_bits;
    } frame_t;

    // status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_FRAME = 2'd1;
    localparam logic [1:0] STATUS_BAD_CODE  = 2'd2;
    localparam logic [1:0] STATUS_UNUSED    = 2'd3;

    // framing constants
    localparam int WIN_LEN    = 69;
    localparam int MIN_TAIL   = 57;
    localparam int TOTAL_BITS = 21;
    localparam int MIN_BITS   = 18;
    localparam logic [6:0] BIT_SAT = 7'd127;

    // 5-to-4 gcr decode, msb set marks an invalid code
    function automatic logic [4:0] gcr_decode(input logic [4:0] code);
        logic [4:0] res;
        case (code)
            5'h09: res = 5'h09;
            5'h0a: res = 5'h0a;
            5'h0b: res = 5'h0b;
            5'h0d: res = 5'h0d;
            5'h0e: res = 5'h0e;
            5'h0f: res = 5'h0f;
            5'h12: res = 5'h02;
            5'h13: res = 5'h03;
            5'h15: res = 5'h05;
            5'h16: res = 5'h06;
            5'h17: res = 5'h07;
            5'h19: res = 5'h00;
            5'h1a: res = 5'h08;
            5'h1b: res = 5'h01;
            5'h1d: res = 5'h04;
            5'h1e: res = 5'h0c;
            default: res = 5'h10;
        endcase
        return res;
    endfunction

endpackage

// ===== src/ogtd_tracker.sv =====
`include "oversampled_gcr_telemetry_decoder_core_assert.svh"

module ogtd_tracker #(
    parameter int MAX_CAPTURE = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [3:0]          pin_select,
    input  ogtd_pkg::sample_t   sample,
    output logic                final_sample,
    output ogtd_pkg::frame_t    frame
);

    localparam int CNT_W = $clog2(MAX_CAPTURE);
    localparam int EXT_W = CNT_W + 1;
    localparam int MUL_W = EXT_W + 11;
    localparam int SUM_W = CNT_W + 2;

    logic [CNT_W-1:0] sample_count_reg, sample_count_next;
    logic             line_level_reg, line_level_next;
    logic             zero_found_reg, zero_found_next;
    logic [CNT_W-1:0] window_start_reg, window_start_next;
    logic [CNT_W-1:0] last_edge_reg, last_edge_next;
    logic [6:0]       bit_total_reg, bit_total_next;
    logic [20:0]      run_bits_reg, run_bits_next;

    logic             level;
    logic [EXT_W-1:0] count;
    logic             in_window;
    logic [EXT_W-1:0] run_span;
    logic [MUL_W-1:0] run_prod;
    logic [CNT_W-1:0] run_len;
    logic [CNT_W-1:0] run_len_eff;
    logic [SUM_W-1:0] bit_sum;

    // selected line and capture bookkeeping
    assign level        = sample.port_sample[pin_select];
    assign final_sample = sample.last_sample ||
                          (sample_count_reg >= CNT_W'(MAX_CAPTURE - 1));
    assign count        = {1'b0, sample_count_reg} + EXT_W'(1);
    assign in_window    = {1'b0, sample_count_reg} <
                          ({1'b0, window_start_reg} + EXT_W'(ogtd_pkg::WIN_LEN));

    // run length in bits, divide by three through a reciprocal multiply
    assign run_span    = {1'b0, sample_count_reg} - {1'b0, last_edge_reg} + EXT_W'(1);
    assign run_prod    = MUL_W'(run_span) * MUL_W'(683);
    assign run_len     = CNT_W'(run_prod >> 11);
    assign run_len_eff = (run_len == '0) ? CNT_W'(1) : run_len;
    assign bit_sum     = SUM_W'(bit_total_reg) + SUM_W'(run_len_eff);

    // frame summary for the decoder
    assign frame.window_ok = zero_found_reg &&
        (({1'b0, window_start_reg} + EXT_W'(ogtd_pkg::MIN_TAIL + 1)) < count);
    assign frame.bit_total = bit_total_reg;
    assign frame.run_bits  = run_bits_reg;

    // edge tracking next state
    always_comb
    begin
        sample_count_next = sample_count_reg;
        line_level_next   = line_level_reg;
        zero_found_next   = zero_found_reg;
        window_start_next = window_start_reg;
        last_edge_next    = last_edge_reg;
        bit_total_next    = bit_total_reg;
        run_bits_next     = run_bits_reg;
        if (step)
        begin
            if (final_sample)
            begin
                sample_count_next = '0;
                line_level_next   = 1'b0;
                zero_found_next   = 1'b0;
                window_start_next = '0;
                last_edge_next    = '0;
                bit_total_next    = '0;
                run_bits_next     = '0;
            end
            else
            begin
                sample_count_next = sample_count_reg + CNT_W'(1);
                if (!zero_found_reg)
                begin
                    if (!level)
                    begin
                        zero_found_next   = 1'b1;
                        window_start_next = sample_count_reg;
                        last_edge_next    = sample_count_reg;
                        line_level_next   = 1'b0;
                    end
                end
                else if (in_window && (level != line_level_reg))
                begin
                    bit_total_next = (bit_sum > SUM_W'(ogtd_pkg::BIT_SAT)) ?
                                     ogtd_pkg::BIT_SAT : bit_sum[6:0];
                    run_bits_next  = (run_bits_reg << run_len_eff) |
                                     (21'd1 << (run_len_eff - CNT_W'(1)));
                    last_edge_next  = sample_count_reg;
                    line_level_next = level;
                end
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= '0;
            line_level_reg   <= 1'b0;
            zero_found_reg   <= 1'b0;
            window_start_reg <= '0;
            last_edge_reg    <= '0;
            bit_total_reg    <= '0;
            run_bits_reg     <= '0;
        end
        else
        begin
            sample_count_reg <= sample_count_next;
            line_level_reg   <= line_level_next;
            zero_found_reg   <= zero_found_next;
            window_start_reg <= window_start_next;
            last_edge_reg    <= last_edge_next;
            bit_total_reg    <= bit_total_next;
            run_bits_reg     <= run_bits_next;
        end
    end

    // no bits gathered before the first low sample
    `OGTD_ASSERT_IMPL(a_idle_empty, !zero_found_reg, (bit_total_reg == '0) && (run_bits_reg == '0))
    // runs never start before the window opens
    `OGTD_ASSERT_IMPL(a_edge_order, zero_found_reg, last_edge_reg >= window_start_reg)
    // a final sample rewinds the capture
    `OGTD_ASSERT_NEXT(a_final_clear, step && final_sample, (sample_count_reg == '0) && !zero_found_reg)

endmodule

// ===== src/ogtd_decode.sv =====
module ogtd_decode (
    input  ogtd_pkg::frame_t  frame,
    output ogtd_pkg::result_t result
);

    logic        count_ok;
    logic [6:0]  pad_len_full;
    logic [1:0]  pad_len;
    logic [20:0] pad_bit;
    logic [20:0] shifted;
    logic [19:0] code_word;
    logic [4:0]  grp0, grp1, grp2, grp3;
    logic [15:0] dec;
    logic        code_bad;
    logic        sum_ok;

    // bit count check and inferred final run
    assign count_ok     = (frame.bit_total >= 7'(ogtd_pkg::MIN_BITS)) &&
                          (frame.bit_total <= 7'(ogtd_pkg::TOTAL_BITS));
    assign pad_len_full = 7'(ogtd_pkg::TOTAL_BITS) - frame.bit_total;
    assign pad_len      = pad_len_full[1:0];
    assign pad_bit      = (pad_len == 2'd0) ? 21'd0 : (21'd1 << (pad_len - 2'd1));
    assign shifted      = (frame.run_bits << pad_len) | pad_bit;
    assign code_word    = shifted[19:0];

    // four gcr groups
    assign grp0 = ogtd_pkg::gcr_decode(code_word[4:0]);
    assign grp1 = ogtd_pkg::gcr_decode(code_word[9:5]);
    assign grp2 = ogtd_pkg::gcr_decode(code_word[14:10]);
    assign grp3 = ogtd_pkg::gcr_decode(code_word[19:15]);
    assign dec  = {grp3[3:0], grp2[3:0], grp1[3:0], grp0[3:0]};
    assign code_bad = grp0[4] | grp1[4] | grp2[4] | grp3[4];

    // nibble xor checksum
    assign sum_ok = ((dec[3:0] ^ dec[7:4] ^ dec[11:8] ^ dec[15:12]) == 4'hf);

    // status and payload
    always_comb
    begin
        result.status    = ogtd_pkg::STATUS_BAD_FRAME;
        result.telemetry = '0;
        if (frame.window_ok && count_ok)
        begin
            if (code_bad || !sum_ok)
            begin
                result.status = ogtd_pkg::STATUS_BAD_CODE;
            end
            else
            begin
                result.status    = ogtd_pkg::STATUS_OK;
                result.telemetry = dec[15:4];
            end
        end
    end

endmodule

// ===== src/oversampled_gcr_telemetry_decoder_core.sv =====
// Decodes one GCR telemetry reply from a 3x oversampled port capture. Each sample
// transaction carries one port word; the line picked by pin_select is tracked for
// its first low level and the runs between edges inside the 69-sample window. A
// sample marked last (or the one at index MAX_CAPTURE-1) closes the capture and
// offers one registered result transaction once it leaves the input register: a
// status and the 12-bit payload, zero unless the status is OK. All other samples
// give no result. One sample is taken per clock; the edge tracker updates its
// registered state from the input register, and the only stall is a closing
// sample that finds the previous result still waiting to be taken.
`include "oversampled_gcr_telemetry_decoder_core_assert.svh"

module oversampled_gcr_telemetry_decoder_core #(
    parameter int MAX_CAPTURE = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_ready,
    input  ogtd_pkg::sample_t sample,
    output logic              result_valid,
    input  logic              result_ready,
    output ogtd_pkg::result_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [3:0]        cfg_data
);

    logic [3:0]        pin_select_reg;
    logic              stage_valid_reg;
    ogtd_pkg::sample_t stage_reg;
    logic              result_valid_reg;
    ogtd_pkg::result_t result_reg;

    logic              stage_final;
    logic              result_free;
    logic              advance;
    ogtd_pkg::frame_t  frame;
    ogtd_pkg::result_t frame_result;

    // configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pin_select_reg <= '0;
        end
        else if (cfg_valid)
        begin
            pin_select_reg <= cfg_data;
        end
    end

    // stage control
    assign result_free  = !result_valid_reg || result_ready;
    assign advance      = stage_valid_reg && (!stage_final || result_free);
    assign sample_ready = !stage_valid_reg || advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (sample_ready)
        begin
            stage_valid_reg <= sample_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_ready && sample_valid)
        begin
            stage_reg <= sample;
        end
    end

    // edge and run tracking
    ogtd_tracker #(
        .MAX_CAPTURE (MAX_CAPTURE)
    ) u_tracker (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .pin_select   (pin_select_reg),
        .sample       (stage_reg),
        .final_sample (stage_final),
        .frame        (frame)
    );

    // gcr and checksum decode
    ogtd_decode u_decode (
        .frame  (frame),
        .result (frame_result)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance && stage_final)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && stage_final)
        begin
            result_reg <= frame_result;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // payload is cleared on any failure
    `OGTD_ASSERT_IMPL(a_tele_zero, result_valid && (result.status != ogtd_pkg::STATUS_OK), result.telemetry == '0)
    // the unused status code never appears
    `OGTD_ASSERT_IMPL(a_status_code, result_valid, result.status != ogtd_pkg::STATUS_UNUSED)
    // back pressure only from a closing sample behind a pending result
    `OGTD_ASSERT_IMPL(a_stall_cause, !sample_ready, stage_valid_reg && stage_final && result_valid_reg && !result_ready)
    // a closing sample always lands a result
    `OGTD_ASSERT_NEXT(a_final_result, advance && stage_final, result_valid_reg)

endmodule

// ===== tb/sv/tb_oversampled_gcr_telemetry_decoder_core.sv =====
module tb_oversampled_gcr_telemetry_decoder_core;

    localparam int CAPTURE_DEPTH = 256;
    localparam int RANDOM_ITEMS  = 1800;
    localparam int PHASES        = 5;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 400000;

    localparam logic [7:0] GCR_INVALID = 8'hff;

    // 5-bit line code to nibble, invalid codes marked
    localparam logic [7:0] GCR_TO_NIBBLE [32] = '{
        GCR_INVALID, GCR_INVALID, GCR_INVALID, GCR_INVALID,
        GCR_INVALID, GCR_INVALID, GCR_INVALID, GCR_INVALID,
        GCR_INVALID, 8'd9,        8'd10,       8'd11,
        GCR_INVALID, 8'd13,       8'd14,       8'd15,
        GCR_INVALID, GCR_INVALID, 8'd2,        8'd3,
        GCR_INVALID, 8'd5,        8'd6,        8'd7,
        GCR_INVALID, 8'd0,        8'd8,        8'd1,
        GCR_INVALID, 8'd4,        8'd12,       GCR_INVALID
    };

    // nibble to 5-bit line code, used to build frames
    localparam logic [4:0] NIBBLE_TO_GCR [16] = '{
        5'h19, 5'h1b, 5'h12, 5'h13, 5'h1d, 5'h15, 5'h16, 5'h17,
        5'h1a, 5'h09, 5'h0a, 5'h0b, 5'h1e, 5'h0d, 5'h0e, 5'h0f
    };

    typedef enum int {
        CAP_GOOD,
        CAP_FLIPPED,
        CAP_BAD_SUM,
        CAP_NOISE,
        CAP_CUT,
        CAP_SPILL,
        CAP_FULL
    } capture_kind_t;

    // one directed sample, with a typed reply where it closes a capture
    typedef struct packed {
        logic [15:0]       port;
        logic              last;
        logic              typed;
        ogtd_pkg::result_t want;
    } dir_row_t;

    localparam int DIR_ROWS = 13;
    localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
        // closes at the first sample, so no low level is ever counted
        '{16'h0000, 1'b1, 1'b1, '{ogtd_pkg::STATUS_BAD_FRAME, 12'h000}},
        '{16'hffff, 1'b1, 1'b1, '{ogtd_pkg::STATUS_BAD_FRAME, 12'h000}},
        // first low, two one-sample runs, then a far too short capture
        '{16'hfffe, 1'b0, 1'b0, '{ogtd_pkg::STATUS_OK, 12'h000}},
        '{16'h0001, 1'b0, 1'b0, '{ogtd_pkg::STATUS_OK, 12'h000}},
        '{16'h0000, 1'b0, 1'b0, '{ogtd_pkg::STATUS_OK, 12'h000}},
        '{16'hffff, 1'b1, 1'b1, '{ogtd_pkg::STATUS_BAD_FRAME, 12'h000}},
        // only the selected bit matters
        '{16'h8000, 1'b0, 1'b0, '{ogtd_pkg::STATUS_OK, 12'h000}},
        '{16'h7fff, 1'b0, 1'b0, '{ogtd_pkg::STATUS_OK, 12'h000}},
        '{16'h5555, 1'b0, 1'b0, '{ogtd_pkg::STATUS_OK, 12'h000}},
        '{16'haaaa, 1'b0, 1'b0, '{ogtd_pkg::STATUS_OK, 12'h000}},
        '{16'h5555, 1'b0, 1'b0, '{ogtd_pkg::STATUS_OK, 12'h000}},
        '{16'h0000, 1'b1, 1'b0, '{ogtd_pkg::STATUS_OK, 12'h000}},
        '{16'h0001, 1'b1, 1'b1, '{ogtd_pkg::STATUS_BAD_FRAME, 12'h000}}
    };

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              sample_valid = 1'b0;
    logic              sample_ready;
    ogtd_pkg::sample_t sample       = '0;
    logic              result_valid;
    logic              result_ready = 1'b0;
    ogtd_pkg::result_t result;
    logic              cfg_valid    = 1'b0;
    logic              cfg_ready;
    logic [3:0]        cfg_data     = 4'h0;

    // line tracker state of the predictor
    logic [3:0]  pick_pin    = 4'h0;
    int          smp_idx     = 0;
    logic        run_level   = 1'b0;
    bit          low_seen    = 1'b0;
    int          win_open_at = 0;
    int          edge_at     = 0;
    int          bits_seen   = 0;
    logic [20:0] bit_history = '0;

    ogtd_pkg::result_t reply_q[$];

    bit hold_req    = 1'b0;
    bit hold_active = 1'b0;
    bit idle_off    = 1'b0;

    int samples_sent   = 0;
    int captures_done  = 0;
    int mismatches     = 0;
    int ok_count       = 0;
    int frame_err_count = 0;
    int code_err_count = 0;
    int cycle_count    = 0;

    oversampled_gcr_telemetry_decoder_core #(
        .MAX_CAPTURE(CAPTURE_DEPTH)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_valid(sample_valid),
        .sample_ready(sample_ready),
        .sample      (sample),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // reply for a capture of count samples, from the tracked runs
    function automatic ogtd_pkg::result_t frame_reply(input int count);
        ogtd_pkg::result_t reply;
        logic [20:0]       v;
        logic [15:0]       word;
        logic [7:0]        nib;
        logic [3:0]        parity;
        int                tail;
        bit                bad;
        reply.status    = ogtd_pkg::STATUS_BAD_FRAME;
        reply.telemetry = '0;
        if (low_seen && win_open_at + ogtd_pkg::MIN_TAIL + 1 < count
            && bits_seen >= ogtd_pkg::MIN_BITS && bits_seen <= ogtd_pkg::TOTAL_BITS)
        begin
            tail = ogtd_pkg::TOTAL_BITS - bits_seen;
            v    = bit_history;
            // missing last run: a one followed by zeros
            if (tail > 0)
            begin
                v = (v << tail) | (21'd1 << (tail - 1));
            end
            bad  = 1'b0;
            word = '0;
            for (int g = 0; g < 4; g++)
            begin
                nib = GCR_TO_NIBBLE[v[5*g +: 5]];
                if (nib == GCR_INVALID)
                begin
                    bad = 1'b1;
                end
                else
                begin
                    word[4*g +: 4] = nib[3:0];
                end
            end
            parity = word[15:12] ^ word[11:8] ^ word[7:4] ^ word[3:0];
            if (bad || parity != 4'hf)
            begin
                reply.status = ogtd_pkg::STATUS_BAD_CODE;
            end
            else
            begin
                reply.status    = ogtd_pkg::STATUS_OK;
                reply.telemetry = word[15:4];
            end
        end
        return reply;
    endfunction

    // advance the line tracker by one sample, reply on a closing sample
    function automatic void decode_line_sample(input logic [15:0] port, input logic last,
                                               output bit closes,
                                               output ogtd_pkg::result_t reply);
        int   idx;
        int   run_len;
        logic lvl;
        idx    = smp_idx;
        lvl    = port[pick_pin];
        closes = last || idx >= CAPTURE_DEPTH - 1;
        reply  = '0;
        if (closes)
        begin
            reply       = frame_reply(idx + 1);
            smp_idx     = 0;
            run_level   = 1'b0;
            low_seen    = 1'b0;
            win_open_at = 0;
            edge_at     = 0;
            bits_seen   = 0;
            bit_history = '0;
        end
        else
        begin
            if (!low_seen)
            begin
                if (!lvl)
                begin
                    low_seen    = 1'b1;
                    win_open_at = idx;
                    edge_at     = idx;
                    run_level   = 1'b0;
                end
            end
            else if (idx < win_open_at + ogtd_pkg::WIN_LEN && lvl != run_level)
            begin
                // run of n samples gives (n+1)/3 bits, at least one
                run_len = (idx - edge_at + 1) / 3;
                if (run_len < 1)
                begin
                    run_len = 1;
                end
                bits_seen = bits_seen + run_len;
                if (bits_seen > int'(ogtd_pkg::BIT_SAT))
                begin
                    bits_seen = int'(ogtd_pkg::BIT_SAT);
                end
                bit_history = (bit_history << run_len) | (21'd1 << (run_len - 1));
                edge_at     = idx;
                run_level   = lvl;
            end
            smp_idx = (idx + 1) % 512;
        end
    endfunction

    // random port word carrying the given level on the selected line
    function automatic logic [15:0] line_word(input logic lvl);
        logic [15:0] w;
        w           = 16'($urandom_range(0, 65535));
        w[pick_pin] = lvl;
        return w;
    endfunction

    // offer one sample transaction and predict its reply once taken
    task automatic send_sample(input logic [15:0] port, input logic last,
                               input logic typed, input ogtd_pkg::result_t want);
        bit                closes;
        ogtd_pkg::result_t predicted;
        if (!idle_off && $urandom_range(0, 7) == 0)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= '{port_sample: port, last_sample: last};
        do @(posedge clk); while (!sample_ready);
        samples_sent++;
        decode_line_sample(port, last, closes, predicted);
        if (closes)
        begin
            captures_done++;
            reply_q.push_back(typed ? want : predicted);
        end
    endtask

    // stop offering samples, let every reply out and the pipeline empty
    task automatic drain_replies();
        sample_valid <= 1'b0;
        while (reply_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // build one capture of line levels and send it
    task automatic send_capture(input capture_kind_t kind);
        bit          line_q[$];
        logic [11:0] value;
        logic [3:0]  csum;
        logic [20:0] code;
        logic        lvl;
        int          reps;
        int          cut;
        if (kind == CAP_NOISE)
        begin
            cut = $urandom_range(0, 150);
            if ($urandom_range(0, 1) == 1)
            begin
                repeat (cut) line_q.push_back(1'($urandom_range(0, 1)));
            end
            else
            begin
                // long idle, first low late or never
                repeat (cut) line_q.push_back(1'b1);
                repeat ($urandom_range(0, 60)) line_q.push_back(1'b0);
            end
        end
        else
        begin
            repeat ($urandom_range(0, 8)) line_q.push_back(1'b1);
            value = 12'($urandom_range(0, 4095));
            csum  = 4'hf ^ value[11:8] ^ value[7:4] ^ value[3:0];
            if (kind == CAP_BAD_SUM)
            begin
                csum = csum ^ 4'($urandom_range(1, 15));
            end
            code = {1'b1, NIBBLE_TO_GCR[value[11:8]], NIBBLE_TO_GCR[value[7:4]],
                    NIBBLE_TO_GCR[value[3:0]], NIBBLE_TO_GCR[csum]};
            if (kind == CAP_FLIPPED)
            begin
                cut       = $urandom_range(0, 19);
                code[cut] = ~code[cut];
            end
            // a one toggles the line; each run start jitters by one sample
            lvl = 1'b0;
            for (int i = 20; i >= 0; i--)
            begin
                reps = 3;
                if (code[i])
                begin
                    if (i != 20)
                    begin
                        lvl = ~lvl;
                    end
                    reps = $urandom_range(2, 4);
                end
                repeat (reps) line_q.push_back(lvl);
            end
            case (kind)
                CAP_CUT:
                begin
                    cut = $urandom_range(1, line_q.size() - 1);
                    while (line_q.size() > cut) void'(line_q.pop_back());
                end
                CAP_SPILL:
                begin
                    repeat ($urandom_range(5, 40)) line_q.push_back(1'($urandom_range(0, 1)));
                end
                CAP_FULL:
                begin
                    while (line_q.size() < CAPTURE_DEPTH - 1) line_q.push_back(1'b1);
                end
                default:
                begin
                    repeat ($urandom_range(1, 12)) line_q.push_back(1'b1);
                end
            endcase
        end
        // closing sample, its level never counts
        line_q.push_back(1'($urandom_range(0, 1)));
        foreach (line_q[i])
        begin
            send_sample(line_word(line_q[i]), kind != CAP_FULL && i == line_q.size() - 1,
                        1'b0, '0);
        end
    endtask

    // result side: random stalls, one long hold-off on request
    initial
    begin
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_active = 1'b1;
                result_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req    = 1'b0;
                hold_active = 1'b0;
            end
            else if (!idle_off && $urandom_range(0, 5) == 0)
            begin
                result_ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            else
            begin
                result_ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    // compare each result transaction with the oldest predicted reply
    always @(posedge clk)
    begin : check_replies
        ogtd_pkg::result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (reply_q.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected reply: expected none actual status %0d telemetry %03h",
                         $time, result.status, result.telemetry);
            end
            else
            begin
                want = reply_q.pop_front();
                if (result.status !== want.status)
                begin
                    mismatches++;
                    $display("%0t: status mismatch: expected %0d actual %0d",
                             $time, want.status, result.status);
                end
                if (result.telemetry !== want.telemetry)
                begin
                    mismatches++;
                    $display("%0t: telemetry mismatch: expected %03h actual %03h",
                             $time, want.telemetry, result.telemetry);
                end
                case (result.status)
                    ogtd_pkg::STATUS_OK:        ok_count++;
                    ogtd_pkg::STATUS_BAD_FRAME: frame_err_count++;
                    ogtd_pkg::STATUS_BAD_CODE:  code_err_count++;
                    default:                    ;
                endcase
            end
        end
    end

    // run limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
        $display("status: fail");
        $finish;
    end

    // stimulus
    initial
    begin
        int            phase_start;
        int            roll;
        logic [3:0]    pin;
        capture_kind_t kind;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows on line 0, the reset selection
        foreach (DIR_TABLE[r])
        begin
            send_sample(DIR_TABLE[r].port, DIR_TABLE[r].last, DIR_TABLE[r].typed,
                        DIR_TABLE[r].want);
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            // new line selection, written while idle
            drain_replies();
            pin = (phase == 0) ? 4'hf : (phase == 1) ? 4'h0 : 4'($urandom_range(0, 15));
            cfg_valid <= 1'b1;
            cfg_data  <= pin;
            do @(posedge clk); while (!cfg_ready);
            cfg_valid <= 1'b0;
            pick_pin  = pin;
            idle_off  = (phase == PHASES - 1);

            if (phase == 2)
            begin
                // hold replies back so closing samples back up the input
                hold_req = 1'b1;
                while (!hold_active) @(posedge clk);
                repeat (12)
                begin
                    repeat ($urandom_range(0, 3))
                    begin
                        send_sample(line_word(1'($urandom_range(0, 1))), 1'b0, 1'b0, '0);
                    end
                    send_sample(line_word(1'b0), 1'b1, 1'b0, '0);
                end
            end

            // mostly well-formed frames, some broken, some noise
            phase_start = samples_sent;
            while (samples_sent - phase_start < RANDOM_ITEMS / PHASES)
            begin
                roll = $urandom_range(0, 99);
                if (captures_done % 40 == 7)
                begin
                    kind = CAP_FULL;
                end
                else if (roll < 55)
                begin
                    kind = CAP_GOOD;
                end
                else if (roll < 67)
                begin
                    kind = CAP_FLIPPED;
                end
                else if (roll < 75)
                begin
                    kind = CAP_BAD_SUM;
                end
                else if (roll < 85)
                begin
                    kind = CAP_NOISE;
                end
                else if (roll < 93)
                begin
                    kind = CAP_CUT;
                end
                else
                begin
                    kind = CAP_SPILL;
                end
                send_capture(kind);
            end
        end

        drain_replies();
        $display("sent %0d samples in %0d captures over %0d line selections",
                 samples_sent, captures_done, PHASES + 1);
        $display("replies seen: %0d good, %0d framing errors, %0d code errors, %0d mismatches",
                 ok_count, frame_err_count, code_err_count, mismatches);
        if (mismatches == 0 && reply_q.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/ogtd_pkg.sv
src/ogtd_tracker.sv
src/ogtd_decode.sv
src/oversampled_gcr_telemetry_decoder_core.sv
tb/sv/tb_oversampled_gcr_telemetry_decoder_core.sv
